/* hw/rtl/mafu_pkg.sv */
// ----------------------------------------------------------------------------
// mafu_pkg
// Shared types and constants of the 6502 ALU and flag unit: operation codes,
// the decoded micro-op that travels from the front end to the execute stage,
// reset values and status bit positions.
// ----------------------------------------------------------------------------
package mafu_pkg;

   // operation codes as they arrive on the request channel
   typedef enum logic [5:0] {
      ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
      ACT_EOR = 6'd4,  ACT_CMP = 6'd5,  ACT_CPX = 6'd6,  ACT_CPY = 6'd7,
      ACT_BIT = 6'd8,  ACT_ASL = 6'd9,  ACT_LSR = 6'd10, ACT_ROL = 6'd11,
      ACT_ROR = 6'd12, ACT_INC = 6'd13, ACT_DEC = 6'd14, ACT_INX = 6'd15,
      ACT_INY = 6'd16, ACT_DEX = 6'd17, ACT_DEY = 6'd18, ACT_LDA = 6'd19,
      ACT_LDX = 6'd20, ACT_LDY = 6'd21, ACT_STA = 6'd22, ACT_STX = 6'd23,
      ACT_STY = 6'd24, ACT_TAX = 6'd25, ACT_TAY = 6'd26, ACT_TSX = 6'd27,
      ACT_TXA = 6'd28, ACT_TXS = 6'd29, ACT_TYA = 6'd30, ACT_CLC = 6'd31,
      ACT_CLD = 6'd32, ACT_CLI = 6'd33, ACT_CLV = 6'd34, ACT_SEC = 6'd35,
      ACT_SED = 6'd36, ACT_SEI = 6'd37, ACT_LAX = 6'd38, ACT_SAX = 6'd39,
      ACT_DCP = 6'd40, ACT_ISC = 6'd41, ACT_SLO = 6'd42, ACT_RLA = 6'd43,
      ACT_SRE = 6'd44, ACT_RRA = 6'd45, ACT_NOP = 6'd46
   } action_type;

   // decoded micro-op held in the queue between front end and execute
   typedef struct packed {
      action_type  action;     // unknown codes already folded to NOP
      logic [7:0]  operand;
      logic        on_acc;     // shift or rotate targets A
      logic        mem_write;  // result byte goes back to memory
   } mop_type;

   // queue occupancy seen by the front end and the execute stage
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // default queue depth between the two halves
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET     = 8'hfd;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

endpackage

/* hw/rtl/mafu_req_if.sv */
// ----------------------------------------------------------------------------
// mafu_req_if
// Request channel: one operation code with its fetched operand byte.
// ----------------------------------------------------------------------------
interface mafu_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] action;
   logic [7:0] operand;
   logic       use_accumulator;

   modport source (output valid, output action, output operand,
                   output use_accumulator, input ready);
   modport sink   (input valid, input action, input operand,
                   input use_accumulator, output ready);
endinterface

/* hw/rtl/mafu_rsp_if.sv */
// ----------------------------------------------------------------------------
// mafu_rsp_if
// Response channel: write-back byte and the register file after the operation.
// ----------------------------------------------------------------------------
interface mafu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mem_value;
   logic       mem_write;
   logic [7:0] acc_out;
   logic [7:0] x_out;
   logic [7:0] y_out;
   logic [7:0] status_out;
   logic [7:0] sp_out;

   modport source (output valid, output mem_value, output mem_write,
                   output acc_out, output x_out, output y_out,
                   output status_out, output sp_out, input ready);
   modport sink   (input valid, input mem_value, input mem_write,
                   input acc_out, input x_out, input y_out,
                   input status_out, input sp_out, output ready);
endinterface

/* hw/rtl/mos6502_alu_flag_unit_core.sv */
// ----------------------------------------------------------------------------
// mos6502_alu_flag_unit_core
// Execute unit of a 6502 core: binary arithmetic, logic, compare, shift,
// step, load, store, transfer and flag operations on A, X, Y, P and S.
//
//   channel   direction  handshake     carries
//   req_ch    in         valid/ready   action, operand, use_accumulator
//   rsp_ch    out        valid/ready   mem_value, mem_write, registers
//
// One operation per cycle sustained while responses are taken; a response is
// offered once its request has passed the queue slot (written at the
// transfer) and then the response register.
// The execute stage holds the registers and runs adder, shifter and step
// unit combinationally, so back-to-back operations see each other's state.
// Synchronous reset loads A/X/Y = 0, P = 0x24, S = 0xfd and empties the queue.
// A stalled response holds; requests keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module mos6502_alu_flag_unit_core #(
   parameter int QueueDepth = mafu_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   mafu_req_if.sink    req_ch,
   mafu_rsp_if.source  rsp_ch
);

   mafu_pkg::queue_status_type  q_status;
   mafu_pkg::mop_type           push_mop;
   mafu_pkg::mop_type           head_mop;
   logic                        push_valid;
   logic                        pop;

   // decode and classify
   mafu_front u_front (
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_mop   (push_mop)
   );

   // micro-op queue
   mafu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_mop   (push_mop),
      .pop        (pop),
      .head_mop   (head_mop),
      .q_status   (q_status)
   );

   // execute and respond
   mafu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_mop (head_mop),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* hw/rtl/mafu_front.sv */
// ----------------------------------------------------------------------------
// mafu_front
// Front end: takes request transfers, folds unknown codes to NOP, resolves
// the accumulator target and the memory write, and pushes a micro-op.
// ----------------------------------------------------------------------------
module mafu_front (
   mafu_req_if.sink                    req_ch,
   input  mafu_pkg::queue_status_type  q_status,
   output logic                        push_valid,
   output mafu_pkg::mop_type           push_mop
);

   mafu_pkg::action_type act;

   // accept whenever the queue has room
   assign req_ch.ready = ~q_status.full;
   assign push_valid   = req_ch.valid;

   // fold codes past NOP
   always_comb begin
      if (req_ch.action <= 6'(mafu_pkg::ACT_NOP)) begin
         act = mafu_pkg::action_type'(req_ch.action);
      end else begin
         act = mafu_pkg::ACT_NOP;
      end
   end

   // classify target and write-back
   always_comb begin
      push_mop.action    = act;
      push_mop.operand   = req_ch.operand;
      push_mop.on_acc    = 1'b0;
      push_mop.mem_write = 1'b0;
      case (act)
         mafu_pkg::ACT_ASL, mafu_pkg::ACT_LSR,
         mafu_pkg::ACT_ROL, mafu_pkg::ACT_ROR: begin
            push_mop.on_acc    = req_ch.use_accumulator;
            push_mop.mem_write = ~req_ch.use_accumulator;
         end
         mafu_pkg::ACT_INC, mafu_pkg::ACT_DEC,
         mafu_pkg::ACT_STA, mafu_pkg::ACT_STX, mafu_pkg::ACT_STY,
         mafu_pkg::ACT_SAX, mafu_pkg::ACT_DCP, mafu_pkg::ACT_ISC,
         mafu_pkg::ACT_SLO, mafu_pkg::ACT_RLA, mafu_pkg::ACT_SRE,
         mafu_pkg::ACT_RRA: begin
            push_mop.mem_write = 1'b1;
         end
         default: begin
            push_mop.mem_write = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/mafu_queue.sv */
// ----------------------------------------------------------------------------
// mafu_queue
// Short micro-op queue between front end and execute stage.
// ----------------------------------------------------------------------------
module mafu_queue #(
   parameter int Depth = mafu_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  mafu_pkg::mop_type           push_mop,
   input  logic                        pop,
   output mafu_pkg::mop_type           head_mop,
   output mafu_pkg::queue_status_type  q_status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mafu_pkg::mop_type  slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == CntW'(Depth));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head_mop       = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_mop;
      end
   end

endmodule

/* hw/rtl/mafu_back.sv */
// ----------------------------------------------------------------------------
// mafu_back
// Execute stage: holds A, X, Y, P and S; runs one micro-op per cycle when the
// response slot is free, through shifter, step unit and adder; registers it.
// ----------------------------------------------------------------------------
module mafu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mafu_pkg::mop_type           head_mop,
   input  mafu_pkg::queue_status_type  q_status,
   output logic                        pop,
   mafu_rsp_if.source                  rsp_ch
);

   logic [7:0] acc_ff, acc_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [7:0] p_ff, p_in;
   logic [7:0] sp_ff, sp_in;
   logic       rsp_valid_ff;
   logic [7:0] mem_value_ff;
   logic       mem_write_ff;

   logic [7:0] m;
   logic [7:0] wv;
   logic [7:0] sh_src, sh_r;
   logic       sh_c;
   logic [7:0] st_src, st_r;
   logic       st_down;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic       add_v;
   logic [7:0] cmp_reg, cmp_m;
   logic [8:0] cmp_diff;
   logic [7:0] logic_r;

   // issue when a micro-op waits and the response slot frees up
   assign pop = ~q_status.empty & (~rsp_valid_ff | rsp_ch.ready);
   assign m   = head_mop.operand;

   // shifter: kind from the operation, source A or operand
   always_comb begin
      sh_src = head_mop.on_acc ? acc_ff : m;
      case (head_mop.action)
         mafu_pkg::ACT_LSR, mafu_pkg::ACT_SRE: begin
            sh_c = sh_src[0];
            sh_r = {1'b0, sh_src[7:1]};
         end
         mafu_pkg::ACT_ROL, mafu_pkg::ACT_RLA: begin
            sh_c = sh_src[7];
            sh_r = {sh_src[6:0], p_ff[mafu_pkg::FLAG_C]};
         end
         mafu_pkg::ACT_ROR, mafu_pkg::ACT_RRA: begin
            sh_c = sh_src[0];
            sh_r = {p_ff[mafu_pkg::FLAG_C], sh_src[7:1]};
         end
         default: begin
            sh_c = sh_src[7];
            sh_r = {sh_src[6:0], 1'b0};
         end
      endcase
   end

   // increment and decrement unit
   always_comb begin
      case (head_mop.action)
         mafu_pkg::ACT_INX, mafu_pkg::ACT_DEX: st_src = x_ff;
         mafu_pkg::ACT_INY, mafu_pkg::ACT_DEY: st_src = y_ff;
         default:                              st_src = m;
      endcase
      st_down = (head_mop.action == mafu_pkg::ACT_DEC) ||
                (head_mop.action == mafu_pkg::ACT_DEX) ||
                (head_mop.action == mafu_pkg::ACT_DEY) ||
                (head_mop.action == mafu_pkg::ACT_DCP);
      st_r = st_down ? st_src - 8'd1 : st_src + 8'd1;
   end

   // adder for ADC, SBC, ISC and RRA; subtract adds the complement
   always_comb begin
      case (head_mop.action)
         mafu_pkg::ACT_SBC: add_b = ~m;
         mafu_pkg::ACT_ISC: add_b = ~st_r;
         mafu_pkg::ACT_RRA: add_b = sh_r;
         default:           add_b = m;
      endcase
      add_cin = (head_mop.action == mafu_pkg::ACT_RRA) ? sh_c : p_ff[mafu_pkg::FLAG_C];
      add_sum = {1'b0, acc_ff} + {1'b0, add_b} + {8'd0, add_cin};
      add_v   = (acc_ff[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
   end

   // comparator
   always_comb begin
      case (head_mop.action)
         mafu_pkg::ACT_CPX: cmp_reg = x_ff;
         mafu_pkg::ACT_CPY: cmp_reg = y_ff;
         default:           cmp_reg = acc_ff;
      endcase
      cmp_m    = (head_mop.action == mafu_pkg::ACT_DCP) ? st_r : m;
      cmp_diff = {1'b0, cmp_reg} + {1'b0, ~cmp_m} + 9'd1;
   end

   // logic unit, second operand is the shifted byte for combined ops
   always_comb begin
      case (head_mop.action)
         mafu_pkg::ACT_ORA: logic_r = acc_ff | m;
         mafu_pkg::ACT_EOR: logic_r = acc_ff ^ m;
         mafu_pkg::ACT_SLO: logic_r = acc_ff | sh_r;
         mafu_pkg::ACT_RLA: logic_r = acc_ff & sh_r;
         mafu_pkg::ACT_SRE: logic_r = acc_ff ^ sh_r;
         default:           logic_r = acc_ff & m;
      endcase
   end

   // register and flag update
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      p_in   = p_ff;
      sp_in  = sp_ff;
      wv     = 8'd0;
      case (head_mop.action)
         mafu_pkg::ACT_ADC, mafu_pkg::ACT_SBC,
         mafu_pkg::ACT_ISC, mafu_pkg::ACT_RRA: begin
            acc_in                  = add_sum[7:0];
            p_in[mafu_pkg::FLAG_C]  = add_sum[8];
            p_in[mafu_pkg::FLAG_V]  = add_v;
            p_in[mafu_pkg::FLAG_N]  = add_sum[7];
            p_in[mafu_pkg::FLAG_Z]  = (add_sum[7:0] == 8'd0);
            wv = (head_mop.action == mafu_pkg::ACT_ISC) ? st_r : sh_r;
         end
         mafu_pkg::ACT_AND, mafu_pkg::ACT_ORA, mafu_pkg::ACT_EOR: begin
            acc_in                 = logic_r;
            p_in[mafu_pkg::FLAG_N] = logic_r[7];
            p_in[mafu_pkg::FLAG_Z] = (logic_r == 8'd0);
         end
         mafu_pkg::ACT_SLO, mafu_pkg::ACT_RLA, mafu_pkg::ACT_SRE: begin
            acc_in                 = logic_r;
            wv                     = sh_r;
            p_in[mafu_pkg::FLAG_C] = sh_c;
            p_in[mafu_pkg::FLAG_N] = logic_r[7];
            p_in[mafu_pkg::FLAG_Z] = (logic_r == 8'd0);
         end
         mafu_pkg::ACT_CMP, mafu_pkg::ACT_CPX,
         mafu_pkg::ACT_CPY, mafu_pkg::ACT_DCP: begin
            wv                     = st_r;
            p_in[mafu_pkg::FLAG_N] = cmp_diff[7];
            p_in[mafu_pkg::FLAG_Z] = (cmp_diff[7:0] == 8'd0);
            p_in[mafu_pkg::FLAG_C] = cmp_diff[8];
         end
         mafu_pkg::ACT_BIT: begin
            p_in[7:6]              = m[7:6];
            p_in[mafu_pkg::FLAG_Z] = ((m & acc_ff) == 8'd0);
         end
         mafu_pkg::ACT_ASL, mafu_pkg::ACT_LSR,
         mafu_pkg::ACT_ROL, mafu_pkg::ACT_ROR: begin
            p_in[mafu_pkg::FLAG_C] = sh_c;
            p_in[mafu_pkg::FLAG_N] = sh_r[7];
            p_in[mafu_pkg::FLAG_Z] = (sh_r == 8'd0);
            if (head_mop.on_acc) begin
               acc_in = sh_r;
            end else begin
               wv = sh_r;
            end
         end
         mafu_pkg::ACT_INC, mafu_pkg::ACT_DEC,
         mafu_pkg::ACT_INX, mafu_pkg::ACT_INY,
         mafu_pkg::ACT_DEX, mafu_pkg::ACT_DEY: begin
            wv                     = st_r;
            p_in[mafu_pkg::FLAG_N] = st_r[7];
            p_in[mafu_pkg::FLAG_Z] = (st_r == 8'd0);
            if ((head_mop.action == mafu_pkg::ACT_INX) ||
                (head_mop.action == mafu_pkg::ACT_DEX)) begin
               x_in = st_r;
            end
            if ((head_mop.action == mafu_pkg::ACT_INY) ||
                (head_mop.action == mafu_pkg::ACT_DEY)) begin
               y_in = st_r;
            end
         end
         mafu_pkg::ACT_LDA, mafu_pkg::ACT_LDX,
         mafu_pkg::ACT_LDY, mafu_pkg::ACT_LAX: begin
            p_in[mafu_pkg::FLAG_N] = m[7];
            p_in[mafu_pkg::FLAG_Z] = (m == 8'd0);
            if ((head_mop.action == mafu_pkg::ACT_LDA) ||
                (head_mop.action == mafu_pkg::ACT_LAX)) begin
               acc_in = m;
            end
            if ((head_mop.action == mafu_pkg::ACT_LDX) ||
                (head_mop.action == mafu_pkg::ACT_LAX)) begin
               x_in = m;
            end
            if (head_mop.action == mafu_pkg::ACT_LDY) begin
               y_in = m;
            end
         end
         mafu_pkg::ACT_STA: wv = acc_ff;
         mafu_pkg::ACT_STX: wv = x_ff;
         mafu_pkg::ACT_STY: wv = y_ff;
         mafu_pkg::ACT_SAX: wv = acc_ff & x_ff;
         mafu_pkg::ACT_TAX: begin
            x_in                   = acc_ff;
            p_in[mafu_pkg::FLAG_N] = acc_ff[7];
            p_in[mafu_pkg::FLAG_Z] = (acc_ff == 8'd0);
         end
         mafu_pkg::ACT_TAY: begin
            y_in                   = acc_ff;
            p_in[mafu_pkg::FLAG_N] = acc_ff[7];
            p_in[mafu_pkg::FLAG_Z] = (acc_ff == 8'd0);
         end
         mafu_pkg::ACT_TSX: begin
            x_in                   = sp_ff;
            p_in[mafu_pkg::FLAG_N] = sp_ff[7];
            p_in[mafu_pkg::FLAG_Z] = (sp_ff == 8'd0);
         end
         mafu_pkg::ACT_TXA: begin
            acc_in                 = x_ff;
            p_in[mafu_pkg::FLAG_N] = x_ff[7];
            p_in[mafu_pkg::FLAG_Z] = (x_ff == 8'd0);
         end
         mafu_pkg::ACT_TXS: sp_in = x_ff;
         mafu_pkg::ACT_TYA: begin
            acc_in                 = y_ff;
            p_in[mafu_pkg::FLAG_N] = y_ff[7];
            p_in[mafu_pkg::FLAG_Z] = (y_ff == 8'd0);
         end
         mafu_pkg::ACT_CLC: p_in[mafu_pkg::FLAG_C] = 1'b0;
         mafu_pkg::ACT_CLD: p_in[mafu_pkg::FLAG_D] = 1'b0;
         mafu_pkg::ACT_CLI: p_in[mafu_pkg::FLAG_I] = 1'b0;
         mafu_pkg::ACT_CLV: p_in[mafu_pkg::FLAG_V] = 1'b0;
         mafu_pkg::ACT_SEC: p_in[mafu_pkg::FLAG_C] = 1'b1;
         mafu_pkg::ACT_SED: p_in[mafu_pkg::FLAG_D] = 1'b1;
         mafu_pkg::ACT_SEI: p_in[mafu_pkg::FLAG_I] = 1'b1;
         default: begin
            wv = 8'd0;
         end
      endcase
   end

   // architectural registers and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 8'd0;
         x_ff         <= 8'd0;
         y_ff         <= 8'd0;
         p_ff         <= mafu_pkg::STATUS_RESET;
         sp_ff        <= mafu_pkg::SP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff <= acc_in;
            x_ff   <= x_in;
            y_ff   <= y_in;
            p_ff   <= p_in;
            sp_ff  <= sp_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         mem_write_ff <= head_mop.mem_write;
         mem_value_ff <= head_mop.mem_write ? wv : 8'd0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mem_value  = mem_value_ff;
   assign rsp_ch.mem_write  = mem_write_ff;
   assign rsp_ch.acc_out    = acc_ff;
   assign rsp_ch.x_out      = x_ff;
   assign rsp_ch.y_out      = y_ff;
   assign rsp_ch.status_out = p_ff;
   assign rsp_ch.sp_out     = sp_ff;

endmodule

/* bench/mafu_flag_checker.sv */
// ----------------------------------------------------------------------------
// mafu_flag_checker
// Watches the request and response channels of the 6502 ALU and flag unit.
// Every request transfer is run through a local copy of A, X, Y, P and S.
// The expected response is queued, and each response transfer is compared
// field by field with the oldest entry.
// ----------------------------------------------------------------------------
module mafu_flag_checker (
   input  logic clock,
   input  logic reset,
   mafu_req_if  req_mon,
   mafu_rsp_if  rsp_mon,
   output int   fail_count,
   output int   expected_count
);

   typedef struct packed {
      logic [7:0] mem_value;
      logic       mem_write;
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] status;
      logic [7:0] sp;
   } rsp_fields_type;

   // shadow register file
   logic [7:0] reg_a = 8'h00;
   logic [7:0] reg_x = 8'h00;
   logic [7:0] reg_y = 8'h00;
   logic [7:0] reg_p = mafu_pkg::STATUS_RESET;
   logic [7:0] reg_s = mafu_pkg::SP_RESET;

   rsp_fields_type pending_rsp_q[$];
   int             mismatch_total = 0;

   function automatic void set_nz(input logic [7:0] v);
      reg_p[mafu_pkg::FLAG_N] = v[7];
      reg_p[mafu_pkg::FLAG_Z] = (v == 8'h00);
   endfunction

   // binary add with carry in
   function automatic void add_carry(input logic [7:0] m);
      logic [8:0] sum;
      sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, reg_p[mafu_pkg::FLAG_C]};
      reg_p[mafu_pkg::FLAG_C] = sum[8];
      reg_p[mafu_pkg::FLAG_V] = (reg_a[7] ^ sum[7]) & (m[7] ^ sum[7]);
      reg_a = sum[7:0];
      set_nz(reg_a);
   endfunction

   // binary subtract, carry acts as not-borrow
   function automatic void sub_borrow(input logic [7:0] m);
      logic [8:0] sum;
      sum = {1'b0, reg_a} + {1'b0, ~m} + {8'h00, reg_p[mafu_pkg::FLAG_C]};
      reg_p[mafu_pkg::FLAG_V] = (reg_a[7] ^ sum[7]) & (reg_a[7] ^ m[7]);
      reg_p[mafu_pkg::FLAG_C] = sum[8];
      reg_a = sum[7:0];
      set_nz(reg_a);
   endfunction

   function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      reg_p[mafu_pkg::FLAG_N] = diff[7];
      reg_p[mafu_pkg::FLAG_Z] = (r == m);
      reg_p[mafu_pkg::FLAG_C] = (r >= m);
   endfunction

   // kind is one of the shift or rotate action codes
   function automatic logic [7:0] shift_byte(input logic [5:0] kind, input logic [7:0] v);
      logic       cin;
      logic [7:0] r;
      cin = reg_p[mafu_pkg::FLAG_C];
      case (kind)
         mafu_pkg::ACT_ASL: begin
            reg_p[mafu_pkg::FLAG_C] = v[7];
            r = {v[6:0], 1'b0};
         end
         mafu_pkg::ACT_LSR: begin
            reg_p[mafu_pkg::FLAG_C] = v[0];
            r = {1'b0, v[7:1]};
         end
         mafu_pkg::ACT_ROL: begin
            reg_p[mafu_pkg::FLAG_C] = v[7];
            r = {v[6:0], cin};
         end
         default: begin
            reg_p[mafu_pkg::FLAG_C] = v[0];
            r = {cin, v[7:1]};
         end
      endcase
      set_nz(r);
      return r;
   endfunction

   function automatic logic [7:0] step_byte(input logic [7:0] v, input logic down);
      logic [7:0] r;
      r = down ? v - 8'd1 : v + 8'd1;
      set_nz(r);
      return r;
   endfunction

   // apply one operation to the shadow registers and build its response
   function automatic rsp_fields_type execute_predict(input logic [5:0] act,
                                                      input logic [7:0] m,
                                                      input logic on_acc);
      rsp_fields_type e;
      logic [7:0]     wv;
      logic           wr;
      wv = 8'h00;
      wr = 1'b0;
      case (act)
         mafu_pkg::ACT_ADC: add_carry(m);
         mafu_pkg::ACT_SBC: sub_borrow(m);
         mafu_pkg::ACT_AND: begin
            reg_a = reg_a & m;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_ORA: begin
            reg_a = reg_a | m;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_EOR: begin
            reg_a = reg_a ^ m;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_CMP: compare_reg(reg_a, m);
         mafu_pkg::ACT_CPX: compare_reg(reg_x, m);
         mafu_pkg::ACT_CPY: compare_reg(reg_y, m);
         mafu_pkg::ACT_BIT: begin
            reg_p[mafu_pkg::FLAG_N] = m[7];
            reg_p[mafu_pkg::FLAG_V] = m[6];
            reg_p[mafu_pkg::FLAG_Z] = ((m & reg_a) == 8'h00);
         end
         mafu_pkg::ACT_ASL, mafu_pkg::ACT_LSR, mafu_pkg::ACT_ROL, mafu_pkg::ACT_ROR: begin
            if (on_acc) begin
               reg_a = shift_byte(act, reg_a);
            end else begin
               wv = shift_byte(act, m);
               wr = 1'b1;
            end
         end
         mafu_pkg::ACT_INC: begin
            wv = step_byte(m, 1'b0);
            wr = 1'b1;
         end
         mafu_pkg::ACT_DEC: begin
            wv = step_byte(m, 1'b1);
            wr = 1'b1;
         end
         mafu_pkg::ACT_INX: reg_x = step_byte(reg_x, 1'b0);
         mafu_pkg::ACT_INY: reg_y = step_byte(reg_y, 1'b0);
         mafu_pkg::ACT_DEX: reg_x = step_byte(reg_x, 1'b1);
         mafu_pkg::ACT_DEY: reg_y = step_byte(reg_y, 1'b1);
         mafu_pkg::ACT_LDA: begin
            reg_a = m;
            set_nz(m);
         end
         mafu_pkg::ACT_LDX: begin
            reg_x = m;
            set_nz(m);
         end
         mafu_pkg::ACT_LDY: begin
            reg_y = m;
            set_nz(m);
         end
         mafu_pkg::ACT_STA: begin
            wv = reg_a;
            wr = 1'b1;
         end
         mafu_pkg::ACT_STX: begin
            wv = reg_x;
            wr = 1'b1;
         end
         mafu_pkg::ACT_STY: begin
            wv = reg_y;
            wr = 1'b1;
         end
         mafu_pkg::ACT_TAX: begin
            reg_x = reg_a;
            set_nz(reg_x);
         end
         mafu_pkg::ACT_TAY: begin
            reg_y = reg_a;
            set_nz(reg_y);
         end
         mafu_pkg::ACT_TSX: begin
            reg_x = reg_s;
            set_nz(reg_x);
         end
         mafu_pkg::ACT_TXA: begin
            reg_a = reg_x;
            set_nz(reg_a);
         end
         // stack pointer load leaves flags alone
         mafu_pkg::ACT_TXS: reg_s = reg_x;
         mafu_pkg::ACT_TYA: begin
            reg_a = reg_y;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_CLC: reg_p[mafu_pkg::FLAG_C] = 1'b0;
         mafu_pkg::ACT_CLD: reg_p[mafu_pkg::FLAG_D] = 1'b0;
         mafu_pkg::ACT_CLI: reg_p[mafu_pkg::FLAG_I] = 1'b0;
         mafu_pkg::ACT_CLV: reg_p[mafu_pkg::FLAG_V] = 1'b0;
         mafu_pkg::ACT_SEC: reg_p[mafu_pkg::FLAG_C] = 1'b1;
         mafu_pkg::ACT_SED: reg_p[mafu_pkg::FLAG_D] = 1'b1;
         mafu_pkg::ACT_SEI: reg_p[mafu_pkg::FLAG_I] = 1'b1;
         mafu_pkg::ACT_LAX: begin
            reg_a = m;
            reg_x = m;
            set_nz(m);
         end
         mafu_pkg::ACT_SAX: begin
            wv = reg_a & reg_x;
            wr = 1'b1;
         end
         // combined ops: memory half first, then the register half
         mafu_pkg::ACT_DCP: begin
            wv = step_byte(m, 1'b1);
            wr = 1'b1;
            compare_reg(reg_a, wv);
         end
         mafu_pkg::ACT_ISC: begin
            wv = step_byte(m, 1'b0);
            wr = 1'b1;
            sub_borrow(wv);
         end
         mafu_pkg::ACT_SLO: begin
            wv = shift_byte(mafu_pkg::ACT_ASL, m);
            wr = 1'b1;
            reg_a = reg_a | wv;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_RLA: begin
            wv = shift_byte(mafu_pkg::ACT_ROL, m);
            wr = 1'b1;
            reg_a = reg_a & wv;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_SRE: begin
            wv = shift_byte(mafu_pkg::ACT_LSR, m);
            wr = 1'b1;
            reg_a = reg_a ^ wv;
            set_nz(reg_a);
         end
         mafu_pkg::ACT_RRA: begin
            wv = shift_byte(mafu_pkg::ACT_ROR, m);
            wr = 1'b1;
            add_carry(wv);
         end
         // NOP and unknown codes change nothing
         default: ;
      endcase
      e.mem_value = wr ? wv : 8'h00;
      e.mem_write = wr;
      e.acc       = reg_a;
      e.x         = reg_x;
      e.y         = reg_y;
      e.status    = reg_p;
      e.sp        = reg_s;
      return e;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         mismatch_total++;
         $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      end
   endfunction

   // predict on request transfers, compare on response transfers
   always @(posedge clock) begin : monitor
      rsp_fields_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            pending_rsp_q.push_back(execute_predict(req_mon.action, req_mon.operand,
                                                    req_mon.use_accumulator));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsp_q.size() == 0) begin
               mismatch_total++;
               $display("%0t: response expected none actual acc %02h status %02h",
                        $time, rsp_mon.acc_out, rsp_mon.status_out);
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("mem_value", want.mem_value, rsp_mon.mem_value);
               check_field("mem_write", {7'b0, want.mem_write}, {7'b0, rsp_mon.mem_write});
               check_field("acc_out", want.acc, rsp_mon.acc_out);
               check_field("x_out", want.x, rsp_mon.x_out);
               check_field("y_out", want.y, rsp_mon.y_out);
               check_field("status_out", want.status, rsp_mon.status_out);
               check_field("sp_out", want.sp, rsp_mon.sp_out);
            end
         end
      end
      fail_count     <= mismatch_total;
      expected_count <= pending_rsp_q.size();
   end

endmodule

/* bench/mos6502_alu_flag_unit_core_tb.sv */
// ----------------------------------------------------------------------------
// mos6502_alu_flag_unit_core_tb
// Stimulus and verdict for the 6502 ALU and flag unit. A directed run over
// flag extremes and corner operations is followed by random operations in
// three idle profiles, with one long response hold-off that backs up the
// request channel. Checking lives in mafu_flag_checker.
// ----------------------------------------------------------------------------
module mos6502_alu_flag_unit_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_asks     = 0;
   int   hold_done     = 0;
   int   cycle_count;
   int   fail_count;
   int   expected_count;

   mafu_req_if req_ch ();
   mafu_rsp_if rsp_ch ();

   mos6502_alu_flag_unit_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mafu_flag_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("mos6502_alu_flag_unit_core: mismatch");
      $finish;
   end

   // response ready: random stalls, or a long counted hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            hold_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // one request transfer; valid stays high on return
   task automatic send_op(input logic [5:0] act, input logic [7:0] opnd, input logic on_acc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.action          <= act;
      req_ch.operand         <= opnd;
      req_ch.use_accumulator <= on_acc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // random operations, operands leaning toward the sign and zero edges
   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         logic [5:0] act;
         logic [7:0] opnd;
         if ($urandom_range(99) < 6)
            act = 6'($urandom_range(63, 47));
         else
            act = 6'($urandom_range(46, 0));
         case ($urandom_range(7))
            0:       opnd = 8'h00;
            1:       opnd = 8'hff;
            2:       opnd = $urandom_range(1) ? 8'h7f : 8'h80;
            default: opnd = 8'($urandom_range(255));
         endcase
         send_op(act, opnd, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.action          = mafu_pkg::ACT_NOP;
      req_ch.operand         = 8'h00;
      req_ch.use_accumulator = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 51;

      // directed: overflow and carry edges
      send_op(mafu_pkg::ACT_LDA, 8'h7f, 1'b0);
      send_op(mafu_pkg::ACT_ADC, 8'h01, 1'b0);
      send_op(mafu_pkg::ACT_ADC, 8'hff, 1'b1);
      send_op(mafu_pkg::ACT_SEC, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_SBC, 8'h80, 1'b0);
      send_op(mafu_pkg::ACT_CLV, 8'hff, 1'b1);
      // bit test touches only N, V and Z
      send_op(mafu_pkg::ACT_BIT, 8'hff, 1'b0);
      send_op(mafu_pkg::ACT_BIT, 8'h00, 1'b0);
      // shifts on the accumulator and on memory
      send_op(mafu_pkg::ACT_ASL, 8'h00, 1'b1);
      send_op(mafu_pkg::ACT_ROR, 8'h01, 1'b0);
      send_op(mafu_pkg::ACT_ROL, 8'hff, 1'b1);
      send_op(mafu_pkg::ACT_LSR, 8'hff, 1'b0);
      // accumulator flag ignored by memory step ops
      send_op(mafu_pkg::ACT_INC, 8'hff, 1'b1);
      send_op(mafu_pkg::ACT_DEC, 8'h00, 1'b1);
      // transfers, stack pointer load without flags
      send_op(mafu_pkg::ACT_LDX, 8'h80, 1'b0);
      send_op(mafu_pkg::ACT_TXS, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_TSX, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_TAY, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_CPY, 8'hff, 1'b0);
      // unknown codes act as no operation
      send_op(6'd63, 8'hff, 1'b1);
      send_op(6'd47, 8'h00, 1'b0);
      // combined ops, rotate carry feeding the add
      send_op(mafu_pkg::ACT_SEC, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_RRA, 8'h01, 1'b0);
      send_op(mafu_pkg::ACT_DCP, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_ISC, 8'hff, 1'b0);
      send_op(mafu_pkg::ACT_LAX, 8'h00, 1'b0);
      send_op(mafu_pkg::ACT_SAX, 8'h00, 1'b0);

      send_random(200);

      send_idle_pct = 51;
      recv_idle_pct = 21;
      send_random(200);

      // no idling; one long response hold-off fills the unit
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks++;
      send_random(40);
      send_random(160);

      req_ch.valid <= 1'b0;
      while (expected_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("mos6502_alu_flag_unit_core: match");
      else
         $display("mos6502_alu_flag_unit_core: mismatch");
      $finish;
   end

endmodule
